/* rtl/tbgd_pkg.sv */
// ----------------------------------------------------------------------------
// tbgd_pkg: shared types and constants of the three-button gesture detector
// Register indexes, reset values, field positions and the saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

package tbgd_pkg;

    localparam int unsigned TICK_W   = 8;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned EV_W     = 5;
    localparam int unsigned SK_W     = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_PERIOD = 2'd0,
        REG_CLICK_MAX   = 2'd1,
        REG_LONG_PRESS  = 2'd2
    } t_cfg_reg;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd25;
    localparam logic [MS_W-1:0]   CLICK_MAX_RST   = 16'd500;
    localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd1200;

    // event flag positions
    localparam int unsigned EV_PLUS_CLICK  = 0;
    localparam int unsigned EV_MINUS_CLICK = 1;
    localparam int unsigned EV_BOTH_LONG   = 2;
    localparam int unsigned EV_ESC_LONG    = 3;
    localparam int unsigned EV_ESC_CLICK   = 4;

    // skip flag positions
    localparam int unsigned SK_PLUS  = 0;
    localparam int unsigned SK_MINUS = 1;
    localparam int unsigned SK_BOTH  = 2;

    // held counter plus tick period, clamped at all ones
    function automatic logic [MS_W-1:0] sat_add(input logic [MS_W-1:0]   held,
                                                input logic [TICK_W-1:0] tick);
        logic [MS_W:0] sum;
        sum = {1'b0, held} + {{(MS_W+1-TICK_W){1'b0}}, tick};
        return sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/three_button_gesture_detector.sv */
// ----------------------------------------------------------------------------
// three_button_gesture_detector
// Click, joint long press and escape gestures from sampled button levels.
// ----------------------------------------------------------------------------
// Each input item is one sample tick carrying the levels of the plus, minus
// and escape buttons (active high) and a clear request. Every tick yields
// exactly one result item holding the five sticky event flags as they stand
// after that tick. The block takes one item per clock: the whole tick update
// is a single pass of short logic from the state registers into the event
// register, which doubles as the output register, so s_axis_tready only
// drops while a result waits and m_axis_tready is low. Configuration writes
// land at once and should be issued only while no tick is in flight.
`default_nettype none

module three_button_gesture_detector (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tick input
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] plus_down, [1] minus_down, [2] esc_down, [3] clear_events, [7:4] zero
    input  wire logic [7:0]                       s_axis_tdata,
    // event output
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] plus_click, [1] minus_click, [2] both_long, [3] esc_long,
    // [4] esc_click, [7:5] zero
    output logic [7:0]                            m_axis_tdata,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [tbgd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tbgd_pkg::MS_W-1:0]        i_cfg_data
);
    import tbgd_pkg::*;

    // configuration
    logic [TICK_W-1:0] r_tick_period;
    logic [MS_W-1:0]   r_click_max;
    logic [MS_W-1:0]   r_long_press;

    // tick state
    logic [2:0]        r_prev;      // bit0 plus, bit1 minus, bit2 escape
    logic [MS_W-1:0]   r_plus_ms;
    logic [MS_W-1:0]   r_minus_ms;
    logic [MS_W-1:0]   r_esc_ms;
    logic [SK_W-1:0]   r_skip;
    logic [EV_W-1:0]   r_ev;        // also the result payload
    logic              r_out_valid;

    logic [2:0]        n_prev;
    logic [MS_W-1:0]   n_plus_ms;
    logic [MS_W-1:0]   n_minus_ms;
    logic [MS_W-1:0]   n_esc_ms;
    logic [SK_W-1:0]   n_skip;
    logic [EV_W-1:0]   n_ev;

    logic in_accept;
    logic p_now, m_now, e_now, clr;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign p_now = s_axis_tdata[0];
    assign m_now = s_axis_tdata[1];
    assign e_now = s_axis_tdata[2];
    assign clr   = s_axis_tdata[3];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8-EV_W){1'b0}}, r_ev};

    // Configuration: unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
            r_click_max   <= CLICK_MAX_RST;
            r_long_press  <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_TICK_PERIOD: r_tick_period <= i_cfg_data[TICK_W-1:0];
                REG_CLICK_MAX:   r_click_max   <= i_cfg_data;
                REG_LONG_PRESS:  r_long_press  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One tick: clear, then plus, then minus, then escape. Minus sees the
    // plus counter and skip flags already updated by this tick.
    always_comb begin
        n_ev       = clr ? '0 : r_ev;
        n_skip     = r_skip;
        n_plus_ms  = r_plus_ms;
        n_minus_ms = r_minus_ms;
        n_esc_ms   = r_esc_ms;

        // plus
        if (!p_now) begin
            if (r_prev[0]) begin
                if (!n_skip[SK_PLUS]) begin
                    if (n_plus_ms < r_click_max) n_ev[EV_PLUS_CLICK] = 1'b1;
                end else begin
                    n_skip[SK_BOTH] = 1'b0;     // re-arm joint detection
                end
                n_skip[SK_PLUS] = 1'b0;
            end
            n_plus_ms = '0;
        end else if (r_prev[0]) begin
            n_plus_ms = sat_add(n_plus_ms, r_tick_period);
            if (n_plus_ms > r_long_press && n_minus_ms > r_long_press &&
                !n_skip[SK_BOTH]) begin
                n_ev[EV_BOTH_LONG] = 1'b1;
                n_skip = '1;
            end
        end

        // minus
        if (!m_now) begin
            if (r_prev[1]) begin
                if (!n_skip[SK_MINUS]) begin
                    if (n_minus_ms < r_click_max) n_ev[EV_MINUS_CLICK] = 1'b1;
                end else begin
                    n_skip[SK_BOTH] = 1'b0;
                end
                n_skip[SK_MINUS] = 1'b0;
            end
            n_minus_ms = '0;
        end else if (r_prev[1]) begin
            n_minus_ms = sat_add(n_minus_ms, r_tick_period);
            if (n_plus_ms > r_long_press && n_minus_ms > r_long_press &&
                !n_skip[SK_BOTH]) begin
                n_ev[EV_BOTH_LONG] = 1'b1;
                n_skip = '1;
            end
        end

        // escape: long press reported once, counter parked at zero after it
        if (!e_now) begin
            n_esc_ms = '0;
            if (r_prev[2]) n_ev[EV_ESC_CLICK] = 1'b1;
        end else if (!n_ev[EV_ESC_LONG] && r_prev[2]) begin
            n_esc_ms = sat_add(n_esc_ms, r_tick_period);
            if (n_esc_ms > r_long_press) begin
                n_ev[EV_ESC_LONG] = 1'b1;
                n_esc_ms = '0;
            end
        end else begin
            n_esc_ms = '0;
        end

        n_prev = {e_now, m_now, p_now};
    end

    // Advance state and load the result on an accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_plus_ms   <= '0;
            r_minus_ms  <= '0;
            r_esc_ms    <= '0;
            r_skip      <= '0;
            r_ev        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_prev     <= n_prev;
                r_plus_ms  <= n_plus_ms;
                r_minus_ms <= n_minus_ms;
                r_esc_ms   <= n_esc_ms;
                r_skip     <= n_skip;
                r_ev       <= n_ev;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Events only fall on a tick that carries a clear request.
    a_sticky_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !clr) |=> ((r_ev & $past(r_ev)) == $past(r_ev)))
        else $error("event flag dropped without clear");

    // Escape counter stays parked while its long press is reported.
    a_esc_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev[EV_ESC_LONG] |-> (r_esc_ms == '0))
        else $error("escape counter running after long press");

    // Joint press latch implies both release clicks are still suppressed.
    a_joint_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip[SK_BOTH] |-> (r_skip[SK_PLUS] && r_skip[SK_MINUS]))
        else $error("joint press latched without release suppression");

    // Input side only stalls behind a waiting result.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
